/* hw/rtl/sskv_pkg.sv */
// Package for the sparse-set key-value store: sizes, command and result words,
// memory request structs and the sequencer state type.
// No dependencies.
package sskv_pkg;

    localparam int KEY_BITS   = 8;
    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int POS_BITS   = $clog2(CAPACITY);
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);
    localparam int KEY_SLOTS  = 1 << KEY_BITS;

    typedef enum logic [2:0] {
        KIND_INSERT = 3'd0,
        KIND_ERASE  = 3'd1,
        KIND_LOOKUP = 3'd2,
        KIND_READ   = 3'd3,
        KIND_WRITE  = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NOT_FOUND = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_RANGE     = 2'd3
    } status_t;

    typedef struct packed {
        kind_t                  kind;
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
        logic [POS_BITS-1:0]    position;
    } cmd_t;

    typedef struct packed {
        status_t                status;
        logic [KEY_BITS-1:0]    out_key;
        logic [VALUE_BITS-1:0]  out_value;
        logic [COUNT_BITS-1:0]  entry_count;
    } result_t;

    typedef struct packed {
        logic [KEY_BITS-1:0]    key;
        logic [VALUE_BITS-1:0]  value;
    } dense_entry_t;

    typedef struct packed {
        logic                   we;
        logic [KEY_BITS-1:0]    waddr;
        logic [POS_BITS-1:0]    wdata;
        logic [KEY_BITS-1:0]    raddr;
    } idx_req_t;

    typedef struct packed {
        logic                   we;
        logic [POS_BITS-1:0]    waddr;
        dense_entry_t           wdata;
        logic [POS_BITS-1:0]    raddr;
    } dense_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INDEX,
        ST_DENSE,
        ST_MOVE,
        ST_POS
    } state_t;

endpackage

/* hw/rtl/sskv_ram.sv */
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data. No dependencies.
module sskv_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/sskv_ctrl.sv */
// Sequencer for the sparse-set store: reads the index and dense memories,
// checks membership, writes back and forms the result word.
// Depends on sskv_pkg.
module sskv_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  sskv_pkg::cmd_t              cmd,
    output logic                        busy,
    output logic                        done,
    output sskv_pkg::result_t           result,
    output sskv_pkg::idx_req_t          idx_req,
    input  logic [sskv_pkg::POS_BITS-1:0] idx_rdata,
    output sskv_pkg::dense_req_t        dense_req,
    input  sskv_pkg::dense_entry_t      dense_rdata
);

    sskv_pkg::state_t                      state_reg, state_next;
    sskv_pkg::cmd_t                        cmd_reg, cmd_next;
    logic [sskv_pkg::COUNT_BITS-1:0]       count_reg, count_next;
    logic [sskv_pkg::POS_BITS-1:0]         pos_reg, pos_next;
    logic                                  done_reg, done_next;
    sskv_pkg::result_t                     result_reg, result_next;
    logic [sskv_pkg::COUNT_BITS-1:0]       last;

    assign last = count_reg - sskv_pkg::COUNT_BITS'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sskv_pkg::ST_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pos_reg    <= pos_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        count_next  = count_reg;
        pos_next    = pos_reg;
        done_next   = 1'b0;
        result_next = result_reg;

        idx_req         = '0;
        idx_req.raddr   = cmd_reg.key;
        dense_req       = '0;
        dense_req.raddr = pos_reg;

        case (state_reg)
            sskv_pkg::ST_IDLE:
            begin
                idx_req.raddr   = cmd.key;
                dense_req.raddr = cmd.position;
                if (start)
                begin
                    cmd_next = cmd;
                    case (cmd.kind)
                        sskv_pkg::KIND_INSERT, sskv_pkg::KIND_ERASE,
                        sskv_pkg::KIND_LOOKUP, sskv_pkg::KIND_WRITE:
                        begin
                            state_next = sskv_pkg::ST_INDEX;
                        end
                        sskv_pkg::KIND_READ:
                        begin
                            state_next = sskv_pkg::ST_POS;
                        end
                        default:
                        begin
                            // unused kinds: report ok and the count, change nothing
                            done_next               = 1'b1;
                            result_next             = '0;
                            result_next.status      = sskv_pkg::STATUS_OK;
                            result_next.entry_count = count_reg;
                        end
                    endcase
                end
            end

            sskv_pkg::ST_INDEX:
            begin
                // index word gives the candidate dense slot
                dense_req.raddr = idx_rdata;
                pos_next        = idx_rdata;
                state_next      = sskv_pkg::ST_DENSE;
            end

            sskv_pkg::ST_DENSE:
            begin
                state_next              = sskv_pkg::ST_IDLE;
                done_next               = 1'b1;
                result_next             = '0;
                result_next.status      = sskv_pkg::STATUS_OK;
                result_next.entry_count = count_reg;
                // member only when slot is live and its key matches
                if ((sskv_pkg::COUNT_BITS'(pos_reg) < count_reg)
                    && (dense_rdata.key == cmd_reg.key))
                begin
                    case (cmd_reg.kind)
                        sskv_pkg::KIND_INSERT, sskv_pkg::KIND_WRITE:
                        begin
                            dense_req.we          = 1'b1;
                            dense_req.waddr       = pos_reg;
                            dense_req.wdata.key   = cmd_reg.key;
                            dense_req.wdata.value = cmd_reg.value;
                        end
                        sskv_pkg::KIND_ERASE:
                        begin
                            // fetch the last entry to fill the hole
                            dense_req.raddr = last[sskv_pkg::POS_BITS-1:0];
                            done_next       = 1'b0;
                            state_next      = sskv_pkg::ST_MOVE;
                        end
                        sskv_pkg::KIND_LOOKUP:
                        begin
                            result_next.out_value = dense_rdata.value;
                        end
                        default:
                        begin
                        end
                    endcase
                end
                else
                begin
                    case (cmd_reg.kind)
                        sskv_pkg::KIND_INSERT:
                        begin
                            if (count_reg >= sskv_pkg::COUNT_BITS'(sskv_pkg::CAPACITY))
                            begin
                                result_next.status = sskv_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                dense_req.we            = 1'b1;
                                dense_req.waddr         = count_reg[sskv_pkg::POS_BITS-1:0];
                                dense_req.wdata.key     = cmd_reg.key;
                                dense_req.wdata.value   = cmd_reg.value;
                                idx_req.we              = 1'b1;
                                idx_req.waddr           = cmd_reg.key;
                                idx_req.wdata           = count_reg[sskv_pkg::POS_BITS-1:0];
                                count_next              = count_reg + sskv_pkg::COUNT_BITS'(1);
                                result_next.entry_count = count_next;
                            end
                        end
                        default:
                        begin
                            result_next.status = sskv_pkg::STATUS_NOT_FOUND;
                        end
                    endcase
                end
            end

            sskv_pkg::ST_MOVE:
            begin
                // move last entry into the hole and repoint its index word
                dense_req.we            = 1'b1;
                dense_req.waddr         = pos_reg;
                dense_req.wdata         = dense_rdata;
                idx_req.we              = 1'b1;
                idx_req.waddr           = dense_rdata.key;
                idx_req.wdata           = pos_reg;
                count_next              = last;
                done_next               = 1'b1;
                result_next             = '0;
                result_next.status      = sskv_pkg::STATUS_OK;
                result_next.entry_count = last;
                state_next              = sskv_pkg::ST_IDLE;
            end

            sskv_pkg::ST_POS:
            begin
                done_next               = 1'b1;
                result_next             = '0;
                result_next.entry_count = count_reg;
                if (sskv_pkg::COUNT_BITS'(cmd_reg.position) < count_reg)
                begin
                    result_next.status    = sskv_pkg::STATUS_OK;
                    result_next.out_key   = dense_rdata.key;
                    result_next.out_value = dense_rdata.value;
                end
                else
                begin
                    result_next.status = sskv_pkg::STATUS_RANGE;
                end
                state_next = sskv_pkg::ST_IDLE;
            end

            default:
            begin
                state_next = sskv_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy   = (state_reg != sskv_pkg::ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* hw/rtl/sparse_set_key_value_store.sv */
// Top level of the sparse-set key-value store: sequencer plus index and dense
// memories. Depends on sskv_pkg, sskv_ram and sskv_ctrl.
//
// Usage: drive cmd and raise start while busy is low; the word is taken at
// that clock edge. cmd.kind selects insert, erase, lookup, read at a dense
// position or value write. Exactly one result word follows on result, valid
// for one cycle while done is high; the receiver must take it then.
// Insert, lookup and write step through an index read, a dense read and the
// write-back or result; erase adds one more dense read for the last entry,
// then moves it into the hole; a position read needs only the dense read, and
// unused kinds answer straight from idle. The single read port of each memory
// puts these steps one after another. busy falls on the cycle done rises, so
// a new command may be issued while the result shows.
// Reset clears the entry count and the sequencer; memory contents are left
// as they are, since membership is checked against the live dense keys and
// needs no clearing pass.
module sparse_set_key_value_store (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  sskv_pkg::cmd_t       cmd,
    output logic                 busy,
    output logic                 done,
    output sskv_pkg::result_t    result
);

    sskv_pkg::idx_req_t                 idx_req;
    sskv_pkg::dense_req_t               dense_req;
    logic [sskv_pkg::POS_BITS-1:0]      idx_rdata;
    sskv_pkg::dense_entry_t             dense_rdata;

    sskv_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .cmd         (cmd),
        .busy        (busy),
        .done        (done),
        .result      (result),
        .idx_req     (idx_req),
        .idx_rdata   (idx_rdata),
        .dense_req   (dense_req),
        .dense_rdata (dense_rdata)
    );

    sskv_ram #(
        .DEPTH (sskv_pkg::KEY_SLOTS),
        .WIDTH (sskv_pkg::POS_BITS)
    ) u_index_ram (
        .clk   (clk),
        .we    (idx_req.we),
        .waddr (idx_req.waddr),
        .wdata (idx_req.wdata),
        .raddr (idx_req.raddr),
        .rdata (idx_rdata)
    );

    sskv_ram #(
        .DEPTH (sskv_pkg::CAPACITY),
        .WIDTH ($bits(sskv_pkg::dense_entry_t))
    ) u_dense_ram (
        .clk   (clk),
        .we    (dense_req.we),
        .waddr (dense_req.waddr),
        .wdata (dense_req.wdata),
        .raddr (dense_req.raddr),
        .rdata (dense_rdata)
    );

endmodule

/* tb/tb_sparse_set_key_value_store.sv */
// Self-checking testbench for the sparse-set key-value store: directed and random
// command words, a built-in predictor of the store and a result checker.
// Depends on sskv_pkg and sparse_set_key_value_store.
`timescale 1ns / 100ps

module tb_sparse_set_key_value_store;

    localparam int RANDOM_ITEMS   = 700;
    localparam int CALM_TAIL      = 80;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SPARE_KINDS    = 3;
    localparam int MAX_GAP        = 14;
    // cumulative percentages per tide: fill, churn, drain
    localparam int INSERT_CUT [3] = '{62, 37, 17};
    localparam int ERASE_CUT  [3] = '{70, 55, 60};
    localparam int LOOKUP_CUT     = 77;
    localparam int WRITE_CUT      = 85;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    sskv_pkg::cmd_t    cmd = '0;
    logic              busy;
    logic              done;
    sskv_pkg::result_t result;

    sparse_set_key_value_store dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    sskv_pkg::cmd_t    queued_cmds [$];
    sskv_pkg::result_t due_results [$];
    logic    word_taken = 1'b0;
    int      planned_n = 0;
    int      accepted_n = 0;
    int      checked_n = 0;
    int      mismatches = 0;
    int      idle_cycles = 0;

    // predicted store contents
    bit [sskv_pkg::POS_BITS-1:0]   slot_of [sskv_pkg::KEY_SLOTS];
    bit [sskv_pkg::KEY_BITS-1:0]   key_at [sskv_pkg::CAPACITY];
    bit [sskv_pkg::VALUE_BITS-1:0] val_at [sskv_pkg::CAPACITY];
    int                            stored = 0;
    int                            full_rejects = 0;
    int                            missing_keys = 0;
    int                            range_reads = 0;
    int                            peak_entries = 0;

    // membership seen by the stimulus builder, so that only keys whose index
    // slot has been written are ever erased, looked up or written
    bit live_flag [sskv_pkg::KEY_SLOTS];
    bit ever_flag [sskv_pkg::KEY_SLOTS];
    int live_keys [$];
    int ever_keys [$];
    int live_n = 0;

    function automatic sskv_pkg::result_t store_apply(sskv_pkg::cmd_t c);
        sskv_pkg::result_t             r;
        bit [sskv_pkg::POS_BITS-1:0]   at;
        bit [sskv_pkg::POS_BITS-1:0]   last;
        bit [sskv_pkg::KEY_BITS-1:0]   moved;
        bit                            hit;
        r = '0;
        r.status = sskv_pkg::STATUS_OK;
        at = slot_of[c.key];
        hit = (at < stored) && (key_at[at] == c.key);
        case (c.kind)
            sskv_pkg::KIND_INSERT:
            begin
                if (hit)
                    val_at[at] = c.value;
                else if (stored >= sskv_pkg::CAPACITY)
                begin
                    r.status = sskv_pkg::STATUS_FULL;
                    full_rejects++;
                end
                else
                begin
                    key_at[stored] = c.key;
                    val_at[stored] = c.value;
                    slot_of[c.key] = sskv_pkg::POS_BITS'(stored);
                    stored++;
                end
            end
            sskv_pkg::KIND_ERASE:
            begin
                if (hit)
                begin
                    // fill the hole with the last entry and repoint its slot
                    last = sskv_pkg::POS_BITS'(stored - 1);
                    moved = key_at[last];
                    key_at[at] = moved;
                    val_at[at] = val_at[last];
                    slot_of[moved] = at;
                    stored--;
                end
                else
                begin
                    r.status = sskv_pkg::STATUS_NOT_FOUND;
                    missing_keys++;
                end
            end
            sskv_pkg::KIND_LOOKUP:
            begin
                if (hit)
                    r.out_value = val_at[at];
                else
                begin
                    r.status = sskv_pkg::STATUS_NOT_FOUND;
                    missing_keys++;
                end
            end
            sskv_pkg::KIND_READ:
            begin
                if (c.position < stored)
                begin
                    r.out_key = key_at[c.position];
                    r.out_value = val_at[c.position];
                end
                else
                begin
                    r.status = sskv_pkg::STATUS_RANGE;
                    range_reads++;
                end
            end
            sskv_pkg::KIND_WRITE:
            begin
                if (hit)
                    val_at[at] = c.value;
                else
                begin
                    r.status = sskv_pkg::STATUS_NOT_FOUND;
                    missing_keys++;
                end
            end
            default:
            begin
            end
        endcase
        if (stored > peak_entries)
            peak_entries = stored;
        r.entry_count = sskv_pkg::COUNT_BITS'(stored);
        return r;
    endfunction

    task automatic plan_cmd(input sskv_pkg::kind_t kind,
                            input logic [sskv_pkg::KEY_BITS-1:0] key,
                            input logic [sskv_pkg::VALUE_BITS-1:0] value,
                            input logic [sskv_pkg::POS_BITS-1:0] position);
        sskv_pkg::cmd_t c;
        int             where [$];
        c.kind = kind;
        c.key = key;
        c.value = value;
        c.position = position;
        queued_cmds = {queued_cmds, c};
        case (kind)
            sskv_pkg::KIND_INSERT:
            begin
                if (!live_flag[key] && live_n < sskv_pkg::CAPACITY)
                begin
                    live_flag[key] = 1'b1;
                    live_keys = {live_keys, int'(key)};
                    live_n++;
                    if (!ever_flag[key])
                    begin
                        ever_flag[key] = 1'b1;
                        ever_keys = {ever_keys, int'(key)};
                    end
                end
            end
            sskv_pkg::KIND_ERASE:
            begin
                if (live_flag[key])
                begin
                    live_flag[key] = 1'b0;
                    where = live_keys.find_first_index(x) with (x == key);
                    live_keys.delete(where[0]);
                    live_n--;
                end
            end
            default:
            begin
            end
        endcase
    endtask

    // -1 when no key has been stored yet
    function automatic int pick_known();
        if (live_keys.size() != 0 && $urandom_range(0, 9) < 7)
            return live_keys[$urandom_range(0, live_keys.size() - 1)];
        if (ever_keys.size() != 0)
            return ever_keys[$urandom_range(0, ever_keys.size() - 1)];
        return -1;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0h got %0h", $time, what, want, got);
        end
    endtask

    // driver: present one word at a time, hold it until taken
    int burst_left = 0;
    int gap_odds = 20;
    int issued_n = 0;

    always @(negedge clk)
    begin : driver
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else if (!start || word_taken)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
                start <= 1'b0;
            end
            else if (queued_cmds.size() == 0)
            begin
                start <= 1'b0;
            end
            else if (queued_cmds.size() > CALM_TAIL && $urandom_range(0, 99) < gap_odds)
            begin
                burst_left = $urandom_range(1, MAX_GAP) - 1;
                start <= 1'b0;
            end
            else
            begin
                cmd <= queued_cmds.pop_front();
                start <= 1'b1;
                issued_n++;
                // vary the idling density so some stretches run back to back
                if (issued_n % 50 == 0)
                begin
                    case ($urandom_range(0, 2))
                        0: gap_odds = 0;
                        1: gap_odds = 15;
                        default: gap_odds = 50;
                    endcase
                end
            end
        end
    end

    // monitor: check result words, then predict the word taken at this edge
    always @(posedge clk)
    begin : monitor
        sskv_pkg::result_t want;
        sskv_pkg::result_t predicted;
        bit                took_now;
        if (!rst_n)
        begin
            word_taken <= 1'b0;
        end
        else
        begin
            took_now = start && !busy;
            if (done)
            begin
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result word with nothing expected, got %0h",
                             $time, result);
                end
                else
                begin
                    want = due_results.pop_front();
                    check_field("status", want.status, result.status);
                    check_field("out_key", want.out_key, result.out_key);
                    check_field("out_value", want.out_value, result.out_value);
                    check_field("entry_count", want.entry_count, result.entry_count);
                    checked_n <= checked_n + 1;
                end
            end
            if (took_now)
            begin
                predicted = store_apply(cmd);
                due_results = {due_results, predicted};
                accepted_n <= accepted_n + 1;
            end
            word_taken <= took_now;
            if (took_now || done)
                idle_cycles <= 0;
            else if (idle_cycles + 1 >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        int                              n;
        int                              k;
        int                              roll;
        int                              tide;
        logic [sskv_pkg::VALUE_BITS-1:0] v;

        // empty store, overwrite, hole filling on erase, missing keys, spare kinds
        plan_cmd(sskv_pkg::KIND_READ, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_READ, 8'hFF, '1, 4'd15);
        plan_cmd(sskv_pkg::KIND_INSERT, 8'h00, 32'h0000_0000, 4'd0);
        plan_cmd(sskv_pkg::KIND_INSERT, 8'hFF, 32'hFFFF_FFFF, 4'd15);
        plan_cmd(sskv_pkg::KIND_INSERT, 8'h00, 32'h1234_5678, 4'd0);
        plan_cmd(sskv_pkg::KIND_LOOKUP, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_LOOKUP, 8'hFF, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_WRITE, 8'hFF, 32'hA5A5_A5A5, 4'd0);
        plan_cmd(sskv_pkg::KIND_READ, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_READ, 8'h00, '0, 4'd1);
        plan_cmd(sskv_pkg::KIND_READ, 8'h00, '0, 4'd2);
        plan_cmd(sskv_pkg::KIND_ERASE, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_LOOKUP, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_ERASE, 8'h00, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_WRITE, 8'h00, 32'h5A5A_5A5A, 4'd0);
        plan_cmd(sskv_pkg::KIND_LOOKUP, 8'hFF, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_READ, 8'h00, '0, 4'd0);
        for (n = 0; n < SPARE_KINDS; n++)
            plan_cmd(sskv_pkg::kind_t'(sskv_pkg::KIND_WRITE + 1 + n), 8'hAA,
                     32'h5555_AAAA, 4'd10);
        plan_cmd(sskv_pkg::KIND_ERASE, 8'hFF, '0, 4'd0);
        plan_cmd(sskv_pkg::KIND_LOOKUP, 8'hFF, '0, 4'd0);

        // random part: tides that fill, churn and drain the store
        tide = 0;
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 60 == 0)
                tide = $urandom_range(0, 2);
            roll = $urandom_range(0, 99);
            k = pick_known();
            v = $urandom;
            case ($urandom_range(0, 15))
                0: v = '0;
                1: v = '1;
                default: ;
            endcase
            if (roll < 2)
                plan_cmd(sskv_pkg::kind_t'(sskv_pkg::KIND_WRITE + 1
                                           + $urandom_range(0, SPARE_KINDS - 1)),
                         sskv_pkg::KEY_BITS'($urandom_range(0, sskv_pkg::KEY_SLOTS - 1)),
                         v, sskv_pkg::POS_BITS'($urandom_range(0, 15)));
            else if (roll < INSERT_CUT[tide])
            begin
                // once full, only retry keys whose slot is already written
                if (live_n >= sskv_pkg::CAPACITY)
                    plan_cmd(sskv_pkg::KIND_INSERT, sskv_pkg::KEY_BITS'(k), v,
                             sskv_pkg::POS_BITS'($urandom_range(0, 15)));
                else if (live_n != 0 && $urandom_range(0, 3) == 0)
                    plan_cmd(sskv_pkg::KIND_INSERT,
                             sskv_pkg::KEY_BITS'(live_keys[$urandom_range(0, live_n - 1)]),
                             v, sskv_pkg::POS_BITS'($urandom_range(0, 15)));
                else
                    plan_cmd(sskv_pkg::KIND_INSERT,
                             sskv_pkg::KEY_BITS'($urandom_range(0, sskv_pkg::KEY_SLOTS - 1)),
                             v, sskv_pkg::POS_BITS'($urandom_range(0, 15)));
            end
            else if (k < 0 || roll >= WRITE_CUT)
                plan_cmd(sskv_pkg::KIND_READ,
                         sskv_pkg::KEY_BITS'($urandom_range(0, sskv_pkg::KEY_SLOTS - 1)),
                         v, sskv_pkg::POS_BITS'($urandom_range(0, 15)));
            else if (roll < ERASE_CUT[tide])
                plan_cmd(sskv_pkg::KIND_ERASE, sskv_pkg::KEY_BITS'(k), v,
                         sskv_pkg::POS_BITS'($urandom_range(0, 15)));
            else if (roll < LOOKUP_CUT)
                plan_cmd(sskv_pkg::KIND_LOOKUP, sskv_pkg::KEY_BITS'(k), v,
                         sskv_pkg::POS_BITS'($urandom_range(0, 15)));
            else
                plan_cmd(sskv_pkg::KIND_WRITE, sskv_pkg::KEY_BITS'(k), v,
                         sskv_pkg::POS_BITS'($urandom_range(0, 15)));
        end
        planned_n = queued_cmds.size();

        repeat (4) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        wait (accepted_n == planned_n);
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d command words, checked %0d results; peak of %0d entries.",
                 accepted_n, checked_n, peak_entries);
        $display("Saw %0d full-store rejects, %0d missing keys, %0d out-of-range reads.",
                 full_rejects, missing_keys, range_reads);
        if (mismatches == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/sskv_pkg.sv
hw/rtl/sskv_ram.sv
hw/rtl/sskv_ctrl.sv
hw/rtl/sparse_set_key_value_store.sv
tb/tb_sparse_set_key_value_store.sv
